// ===== rtl/multi_channel_confirm_debouncer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel confirm debouncer
// Shared property shapes, all clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_CONFIRM_DEBOUNCER_DEFINES_SVH
`define MULTI_CHANNEL_CONFIRM_DEBOUNCER_DEFINES_SVH

// Same-cycle implication
`define MCCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MCCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mccd_pkg.sv =====
// ----------------------------------------------------------------------------
// mccd_pkg
// Types and constants shared by the debouncer top level and its channel cells.
// ----------------------------------------------------------------------------
package mccd_pkg;

   // Field widths
   localparam int LINE_W   = 8;
   localparam int IDX_W    = 3;
   localparam int EVENT_W  = 32;
   localparam int DEB_W    = 16;
   localparam int ACT_W    = 4;
   localparam int MODE_W   = 2;

   // Stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TIME = 1'b0,
      CSR_ACTIVE_COUNT  = 1'b1
   } csr_index_type;

   // Reset values of the registers
   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd60;
   localparam logic [ACT_W-1:0] ACTIVE_RESET   = 4'd0;

   // Request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_ARM     = 2'd0,
      MODE_POLL    = 2'd1,
      MODE_CONSUME = 2'd2,
      MODE_STATUS  = 2'd3
   } mode_type;

   // Control handed to each channel cell
   typedef struct packed {
      logic     advance;
      mode_type mode;
      logic     active;
      logic     sample;
      logic     consume;
   } cell_ctl_type;

   // Status returned by each channel cell
   typedef struct packed {
      logic               closed;
      logic [EVENT_W-1:0] events;
      logic               pending;
      logic               flipped;
   } cell_stat_type;

endpackage

// ===== rtl/mccd_cell.sv =====
// ----------------------------------------------------------------------------
// mccd_cell
// State of one switch channel: debounced level, disagreement counter,
// wrapping event total and pending flag, updated once per request.
// ----------------------------------------------------------------------------
module mccd_cell #(
   parameter int POLL_PERIOD_MS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mccd_pkg::cell_ctl_type     ctl,
   input  logic [mccd_pkg::DEB_W-1:0] thresh,
   output mccd_pkg::cell_stat_type    stat
);
   import mccd_pkg::*;

   // Largest sample count the counter must hold
   localparam int MAX_NEED = ((1 << DEB_W) - 1) / POLL_PERIOD_MS;
   localparam int CNT_W    = $clog2(MAX_NEED + 1);
   localparam int PROD_W   = CNT_W + $clog2(POLL_PERIOD_MS + 1);

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [EVENT_W-1:0] events_ff, events_in;
   logic               flag_ff, flag_in;

   logic               disagree;
   logic [CNT_W-1:0]   cnt_inc;
   logic [PROD_W-1:0]  reach_prod;
   logic               reach;
   logic               flip;

   // Confirm once (count + 2) periods exceed the debounce time
   assign disagree   = ctl.sample != state_ff;
   assign cnt_inc    = cnt_ff + CNT_W'(1);
   assign reach_prod = (PROD_W'(cnt_inc) + PROD_W'(1)) * PROD_W'(POLL_PERIOD_MS);
   assign reach      = reach_prod > PROD_W'(thresh);
   assign flip       = (ctl.mode == MODE_POLL) && ctl.active && disagree && reach;

   // Next state for the request in the input stage
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      events_in = events_ff;
      flag_in   = flag_ff;
      case (ctl.mode)
         MODE_ARM: begin
            state_in  = ctl.active & ctl.sample;
            cnt_in    = '0;
            events_in = '0;
            flag_in   = 1'b0;
         end
         MODE_POLL: begin
            if (ctl.active) begin
               if (!disagree) begin
                  cnt_in = '0;
               end else if (reach) begin
                  state_in  = ctl.sample;
                  cnt_in    = '0;
                  events_in = events_ff + EVENT_W'(1);
                  flag_in   = 1'b1;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         MODE_CONSUME: begin
            if (ctl.consume) begin
               flag_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Commit when the request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= 1'b0;
         cnt_ff    <= '0;
         events_ff <= '0;
         flag_ff   <= 1'b0;
      end else if (ctl.advance) begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         events_ff <= events_in;
         flag_ff   <= flag_in;
      end
   end

   assign stat.closed  = state_in;
   assign stat.events  = events_in;
   assign stat.pending = flag_ff;
   assign stat.flipped = flip;

endmodule

// ===== rtl/multi_channel_confirm_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_confirm_debouncer
// Sample-and-confirm debouncer for up to MAX_CHANNELS active-low switch lines
// with arm, poll, consume and status requests, one status response per request.
//
//   channel  direction  handshake            payload
//   req_     in         req_tvalid/tready    tuser: mode; tdata: lines, index
//   rsp_     out        rsp_tvalid/tready    tdata: status of channels
//   csr_     in         csr_valid/ready      csr_index, csr_data
//
// One request per cycle sustained while the response is not stalled. rsp_tvalid
// rises once an accepted request has passed the input register and then the
// result register fed by the channel cells. Synchronous reset clears all channel
// state and sets the debounce time to 60 ms and the active count to 0. A stalled
// response holds the result register, and the input register still takes one
// more request behind it.
// ----------------------------------------------------------------------------
module multi_channel_confirm_debouncer #(
   parameter int MAX_CHANNELS   = 8,
   parameter int POLL_PERIOD_MS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mccd_pkg::MODE_W-1:0]     req_tuser,  // [1:0] mode
   input  logic [mccd_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] line_levels, [10:8] index
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mccd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] closed, [32:1] events,
                                                       // [33] pending, [41:34] closed_all,
                                                       // [49:42] changed_now
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mccd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mccd_pkg::CSR_DATA_W-1:0] csr_data
);
   import mccd_pkg::*;

   `include "multi_channel_confirm_debouncer_defines.svh"

   localparam int LIVE_W = $clog2(MAX_CHANNELS + 1);
   localparam int SEL_W  = (LIVE_W > IDX_W) ? LIVE_W : IDX_W;
   localparam int PAD_W  = RSP_DATA_W - (1 + EVENT_W + 1 + 2 * LINE_W);

   // Configuration registers
   logic [DEB_W-1:0] debounce_ff;
   logic [ACT_W-1:0] active_ff;

   // Input stage
   logic              s1_valid_ff;
   mode_type          s1_mode_ff;
   logic [LINE_W-1:0] s1_lines_ff;
   logic [IDX_W-1:0]  s1_idx_ff;

   // Result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  advance;
   logic [LIVE_W-1:0]     live;
   logic                  sel_ok;
   logic [DEB_W-1:0]      thresh;
   logic [MAX_CHANNELS-1:0] active_vec;
   logic [MAX_CHANNELS-1:0] hit_vec;
   cell_ctl_type          ctl [MAX_CHANNELS];
   cell_stat_type         stat [MAX_CHANNELS];

   logic                  sel_closed;
   logic [EVENT_W-1:0]    sel_events;
   logic                  sel_pending;
   logic [LINE_W-1:0]     closed_all;
   logic [LINE_W-1:0]     changed_now;
   logic [LINE_W-1:0]     active_lines;

   // Pipeline flow
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         active_ff   <= ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TIME: debounce_ff <= csr_data[DEB_W-1:0];
            CSR_ACTIVE_COUNT:  active_ff   <= csr_data[ACT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_mode_ff  <= mode_type'(req_tuser);
         s1_lines_ff <= req_tdata[LINE_W-1:0];
         s1_idx_ff   <= req_tdata[LINE_W +: IDX_W];
      end
   end

   // Clamp the channel count and the debounce time
   always_comb begin
      if (ACT_W'(active_ff) > ACT_W'(MAX_CHANNELS) && MAX_CHANNELS < (1 << ACT_W)) begin
         live = LIVE_W'(MAX_CHANNELS);
      end else begin
         live = LIVE_W'(active_ff);
      end
   end

   assign thresh = (debounce_ff < DEB_W'(POLL_PERIOD_MS)) ? DEB_W'(POLL_PERIOD_MS)
                                                          : debounce_ff;
   assign sel_ok = SEL_W'(s1_idx_ff) < SEL_W'(live);

   // Channel cells
   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_ch
      assign active_vec[i] = LIVE_W'(i) < live;
      if (i < LINE_W) begin : g_line
         assign hit_vec[i]    = sel_ok && (s1_idx_ff == IDX_W'(i));
         assign ctl[i].sample = ~s1_lines_ff[i];
      end else begin : g_noline
         assign hit_vec[i]    = 1'b0;
         assign ctl[i].sample = 1'b0;
      end
      assign ctl[i].advance = advance;
      assign ctl[i].mode    = s1_mode_ff;
      assign ctl[i].active  = active_vec[i];
      assign ctl[i].consume = hit_vec[i];

      mccd_cell #(
         .POLL_PERIOD_MS (POLL_PERIOD_MS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[i]),
         .thresh (thresh),
         .stat   (stat[i])
      );
   end

   // Per-line status bits
   for (genvar j = 0; j < LINE_W; j++) begin : g_bits
      if (j < MAX_CHANNELS) begin : g_used
         assign active_lines[j] = active_vec[j];
         assign closed_all[j]   = active_vec[j] & stat[j].closed;
         assign changed_now[j]  = stat[j].flipped;
      end else begin : g_unused
         assign active_lines[j] = 1'b0;
         assign closed_all[j]   = 1'b0;
         assign changed_now[j]  = 1'b0;
      end
   end

   // Select the status of the indexed channel
   always_comb begin
      sel_closed  = 1'b0;
      sel_events  = '0;
      sel_pending = 1'b0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         if (hit_vec[k]) begin
            sel_closed  = stat[k].closed;
            sel_events  = stat[k].events;
            sel_pending = stat[k].pending;
         end
      end
   end

   assign rsp_data_in = {{PAD_W{1'b0}}, changed_now, closed_all, sel_pending,
                         sel_events, sel_closed};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the datapath
   `MCCD_ASSERT_NOW(a_changed_poll_only, advance && (s1_mode_ff != MODE_POLL), changed_now == '0, "changed_now set outside a poll request")
   `MCCD_ASSERT_NOW(a_changed_active, advance, (changed_now & ~active_lines) == '0, "inactive channel reported as changed")
   `MCCD_ASSERT_NOW(a_closed_active, advance, (closed_all & ~active_lines) == '0, "inactive channel reported as closed")
   `MCCD_ASSERT_NEXT(a_result_loaded, advance, rsp_valid_ff, "request advanced without a response")

endmodule
